// ----- design/mdc_pkg.sv -----
// shared types, constants and helpers for the maze carver
package mdc_pkg;

  localparam int ROWS_DEF        = 16;
  localparam int COLS_DEF        = 16;
  localparam int STACK_DEPTH_DEF = 64;

  typedef enum logic [1:0] {
    MODE_START = 2'd0,
    MODE_STEP  = 2'd1,
    MODE_READ  = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    KIND_PASSAGE = 2'd0,
    KIND_WALL    = 2'd1,
    KIND_START   = 2'd2,
    KIND_GOAL    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_WAIT = 2'd1,
    PH_DONE = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    DIR_NORTH = 2'd0,
    DIR_EAST  = 2'd1,
    DIR_SOUTH = 2'd2,
    DIR_WEST  = 2'd3
  } dir_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_START,
    S_TRY,
    S_CHECK,
    S_POP,
    S_CARVE_MID,
    S_CARVE_END,
    S_FIN_START,
    S_FIN_GOAL,
    S_READ
  } state_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic wr_data;
    logic clear_req;
  } grid_ctl_t;

  // four swap draws over the list north, east, south, west
  function automatic logic [7:0] shuffle_order(input logic [7:0] bits);
    logic [1:0] d [4];
    logic [1:0] r;
    logic [1:0] t;
    d[0] = 2'd0;
    d[1] = 2'd1;
    d[2] = 2'd2;
    d[3] = 2'd3;
    for (int i = 0; i < 4; i++) begin
      r    = bits[2*i +: 2];
      t    = d[r];
      d[r] = d[i];
      d[i] = t;
    end
    return {d[3], d[2], d[1], d[0]};
  endfunction

endpackage

// ----- design/mdc_if.sv -----
// valid/ready channel interfaces for the maze carver
interface mdc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] random_bits;
  logic [3:0] read_row;
  logic [3:0] read_col;

  modport source (output valid, output mode, output random_bits, output read_row,
                  output read_col, input ready);
  modport sink (input valid, input mode, input random_bits, input read_row,
                input read_col, output ready);
endinterface

interface mdc_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] cell_row;
  logic [3:0] cell_col;
  logic [1:0] cell_kind;
  logic       finished;
  logic       last;

  modport source (output valid, output cell_row, output cell_col, output cell_kind,
                  output finished, output last, input ready);
  modport sink (input valid, input cell_row, input cell_col, input cell_kind,
                input finished, input last, output ready);
endinterface

// ----- design/mdc_grid.sv -----
// one-bit-per-cell wall memory with a sweep that sets every cell to wall
module mdc_grid #(
  parameter int AW = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  mdc_pkg::grid_ctl_t ctl,
  input  logic [AW-1:0]     wr_addr,
  input  logic [AW-1:0]     rd_addr,
  output logic              rd_data,
  output logic              busy
);
  import mdc_pkg::*;

  logic          mem [2**AW];
  logic          clr_active_r;
  logic [AW-1:0] clr_cnt_r;
  logic          rd_data_r;

  // sweep runs after reset and on every clear request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_cnt_r    <= '0;
    end else if (ctl.clear_req) begin
      clr_active_r <= 1'b1;
      clr_cnt_r    <= '0;
    end else if (clr_active_r) begin
      clr_cnt_r <= clr_cnt_r + AW'(1);
      if (&clr_cnt_r) begin
        clr_active_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_active_r) begin
      mem[clr_cnt_r] <= 1'b1;
    end else if (ctl.wr_en) begin
      mem[wr_addr] <= ctl.wr_data;
    end
    if (ctl.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;
  assign busy    = clr_active_r;

endmodule

// ----- design/maze_dfs_carver_core.sv -----
// random depth-first maze carver, top level
//
//  channel | dir | payload                                          | role
//  in_ch   | in  | mode, random_bits, read_row, read_col            | start, byte, read
//  out_ch  | out | cell_row, cell_col, cell_kind, finished, last    | carved or read cell
//
// start: accept, grid sweep, sweep exit, then the result
// random byte: accept, try and check per direction read from the grid, try per
//   direction out of bounds or on a full stack, try and pop per pop, try to end
//   the walk, emit per result
// read: accept and result; reset: grid sweep, no item is accepted until it ends
// one item at a time; a stalled result holds the walk in its emit state
module maze_dfs_carver_core #(
  parameter int ROWS        = mdc_pkg::ROWS_DEF,
  parameter int COLS        = mdc_pkg::COLS_DEF,
  parameter int STACK_DEPTH = mdc_pkg::STACK_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  mdc_in_if.sink    in_ch,
  mdc_out_if.source out_ch
);
  import mdc_pkg::*;

  localparam int RW  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CW  = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int AW  = RW + CW;
  localparam int SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int DW  = $clog2(STACK_DEPTH + 1);
  localparam int SW  = RW + CW + 8 + 3;

  state_t state_r, state_nxt;
  phase_t phase_r;

  logic [RW-1:0] top_row_r, goal_row_r, tgt_row_r, mid_row_r, rd_row_r;
  logic [CW-1:0] top_col_r, goal_col_r, tgt_col_r, mid_col_r, rd_col_r;
  logic [7:0]    top_order_r;
  logic [2:0]    top_next_r;
  logic [DW-1:0] depth_r;
  logic [3:0]    rr_r, rc_r;
  logic          oob_r;

  logic [SW-1:0] stk_mem [STACK_DEPTH];
  logic [SW-1:0] stk_rd_r;
  logic          stk_rd_en, stk_wr_en;
  logic [DW-1:0] depth_m1, depth_m2;

  grid_ctl_t     gctl;
  logic [AW-1:0] g_wr_addr, g_rd_addr;
  logic          g_rd_data, g_busy;

  logic          out_valid_r;
  logic [3:0]    out_row_r, out_col_r;
  kind_t         out_kind_r;
  logic          out_fin_r, out_last_r;

  logic          emit_en, emit_fin, emit_last, emit_is_read, fire, out_free;
  kind_t         emit_kind, read_kind;
  logic [RW-1:0] emit_row;
  logic [CW-1:0] emit_col;
  logic [RW+3:0] emit_row_ext;
  logic [CW+3:0] emit_col_ext;

  logic          in_fire;
  logic [RW+3:0] in_row_ext;
  logic [CW+3:0] in_col_ext;
  logic          in_oob;

  // direction step
  dir_t          dir;
  logic [RW:0]   row_p2, row_p1;
  logic [CW:0]   col_p2, col_p1;
  logic          dir_ok;
  logic [RW-1:0] try_tgt_row, try_mid_row;
  logic [CW-1:0] try_col_tgt, try_col_mid;
  logic          goal_nz;

  mdc_grid #(.AW(AW)) u_grid (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (gctl),
    .wr_addr (g_wr_addr),
    .rd_addr (g_rd_addr),
    .rd_data (g_rd_data),
    .busy    (g_busy)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign in_row_ext  = {{RW{1'b0}}, in_ch.read_row};
  assign in_col_ext  = {{CW{1'b0}}, in_ch.read_col};
  assign in_oob      = (in_row_ext >= (RW+4)'(ROWS)) || (in_col_ext >= (CW+4)'(COLS));

  assign depth_m1 = depth_r - DW'(1);
  assign depth_m2 = depth_r - DW'(2);
  assign goal_nz  = (goal_row_r != '0) || (goal_col_r != '0);

  always_comb begin
    dir         = dir_t'(top_order_r[{top_next_r[1:0], 1'b0} +: 2]);
    row_p2      = {1'b0, top_row_r} + (RW+1)'(2);
    row_p1      = {1'b0, top_row_r} + (RW+1)'(1);
    col_p2      = {1'b0, top_col_r} + (CW+1)'(2);
    col_p1      = {1'b0, top_col_r} + (CW+1)'(1);
    dir_ok      = 1'b0;
    try_tgt_row = top_row_r;
    try_mid_row = top_row_r;
    try_col_tgt = top_col_r;
    try_col_mid = top_col_r;
    unique case (dir)
      DIR_NORTH: begin
        dir_ok      = ({1'b0, top_col_r} >= (CW+1)'(2));
        try_col_tgt = top_col_r - CW'(2);
        try_col_mid = top_col_r - CW'(1);
      end
      DIR_EAST: begin
        dir_ok      = (row_p2 < (RW+1)'(ROWS));
        try_tgt_row = row_p2[RW-1:0];
        try_mid_row = row_p1[RW-1:0];
      end
      DIR_SOUTH: begin
        dir_ok      = (col_p2 < (CW+1)'(COLS));
        try_col_tgt = col_p2[CW-1:0];
        try_col_mid = col_p1[CW-1:0];
      end
      DIR_WEST: begin
        dir_ok      = ({1'b0, top_row_r} >= (RW+1)'(2));
        try_tgt_row = top_row_r - RW'(2);
        try_mid_row = top_row_r - RW'(1);
      end
      default: dir_ok = 1'b0;
    endcase
    // a push onto a full stack counts as blocked
    dir_ok = dir_ok && (depth_r < DW'(STACK_DEPTH));
  end

  assign out_free = !out_valid_r || out_ch.ready;
  assign fire     = emit_en && out_free;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (!g_busy) begin
          state_nxt = (phase_r == PH_WAIT) ? S_START : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          unique case (in_ch.mode)
            MODE_START: state_nxt = S_CLEAR;
            MODE_STEP: begin
              if (phase_r == PH_WAIT && depth_r != '0) begin
                state_nxt = S_TRY;
              end
            end
            MODE_READ: state_nxt = S_READ;
            default:   state_nxt = S_IDLE;
          endcase
        end
      end
      S_START:     if (fire) state_nxt = S_IDLE;
      S_TRY: begin
        if (top_next_r[2]) begin
          if (depth_r == DW'(1)) begin
            state_nxt = goal_nz ? S_FIN_START : S_FIN_GOAL;
          end else begin
            state_nxt = S_POP;
          end
        end else if (dir_ok) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK:     state_nxt = g_rd_data ? S_CARVE_MID : S_TRY;
      S_POP:       state_nxt = S_TRY;
      S_CARVE_MID: if (fire) state_nxt = S_CARVE_END;
      S_CARVE_END: if (fire) state_nxt = S_IDLE;
      S_FIN_START: if (fire) state_nxt = S_FIN_GOAL;
      S_FIN_GOAL:  if (fire) state_nxt = S_IDLE;
      S_READ:      if (fire) state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    read_kind = g_rd_data ? KIND_WALL : KIND_PASSAGE;
    if (oob_r) begin
      read_kind = KIND_WALL;
    end else if (phase_r == PH_DONE) begin
      if (rd_row_r == goal_row_r && rd_col_r == goal_col_r) begin
        read_kind = KIND_GOAL;
      end else if (rd_row_r == '0 && rd_col_r == '0) begin
        read_kind = KIND_START;
      end
    end
  end

  // outputs of the state machine
  always_comb begin
    gctl         = '0;
    g_wr_addr    = '0;
    g_rd_addr    = {tgt_row_r, tgt_col_r};
    stk_rd_en    = 1'b0;
    stk_wr_en    = 1'b0;
    emit_en      = 1'b0;
    emit_row     = '0;
    emit_col     = '0;
    emit_kind    = KIND_PASSAGE;
    emit_fin     = 1'b0;
    emit_last    = 1'b1;
    emit_is_read = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire && in_ch.mode == MODE_START) begin
          gctl.clear_req = 1'b1;
        end
        if (in_fire && in_ch.mode == MODE_READ && !in_oob) begin
          gctl.rd_en = 1'b1;
          g_rd_addr  = {in_row_ext[RW-1:0], in_col_ext[CW-1:0]};
        end
      end
      S_START: begin
        gctl.wr_en = 1'b1;
        emit_en    = 1'b1;
      end
      S_TRY: begin
        if (top_next_r[2]) begin
          stk_rd_en = (depth_r != DW'(1));
        end else if (dir_ok) begin
          gctl.rd_en = 1'b1;
          g_rd_addr  = {try_tgt_row, try_col_tgt};
        end
      end
      S_CARVE_MID: begin
        gctl.wr_en = 1'b1;
        g_wr_addr  = {mid_row_r, mid_col_r};
        emit_en    = 1'b1;
        emit_row   = mid_row_r;
        emit_col   = mid_col_r;
        emit_last  = 1'b0;
      end
      S_CARVE_END: begin
        gctl.wr_en = 1'b1;
        g_wr_addr  = {tgt_row_r, tgt_col_r};
        emit_en    = 1'b1;
        emit_row   = tgt_row_r;
        emit_col   = tgt_col_r;
        stk_wr_en  = fire;
      end
      S_FIN_START: begin
        emit_en   = 1'b1;
        emit_kind = KIND_START;
        emit_fin  = 1'b1;
        emit_last = 1'b0;
      end
      S_FIN_GOAL: begin
        emit_en   = 1'b1;
        emit_row  = goal_row_r;
        emit_col  = goal_col_r;
        emit_kind = KIND_GOAL;
        emit_fin  = 1'b1;
      end
      S_READ: begin
        emit_en      = 1'b1;
        emit_is_read = 1'b1;
        emit_kind    = read_kind;
        emit_fin     = (phase_r == PH_DONE);
      end
      default: begin
        emit_en = 1'b0;
      end
    endcase
  end

  assign emit_row_ext = {4'b0, emit_row};
  assign emit_col_ext = {4'b0, emit_col};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // walk control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      depth_r    <= '0;
      goal_row_r <= '0;
      goal_col_r <= '0;
    end else begin
      if (state_r == S_IDLE && in_fire && in_ch.mode == MODE_START) begin
        phase_r <= PH_WAIT;
        depth_r <= '0;
      end
      if (state_r == S_START && fire) begin
        depth_r    <= DW'(1);
        goal_row_r <= '0;
        goal_col_r <= '0;
      end
      if (state_r == S_TRY && top_next_r[2]) begin
        depth_r <= depth_m1;
        if (depth_r == DW'(1)) begin
          phase_r <= PH_DONE;
        end
      end
      if (state_r == S_CARVE_END && fire) begin
        depth_r    <= depth_r + DW'(1);
        goal_row_r <= tgt_row_r;
        goal_col_r <= tgt_col_r;
      end
    end
  end

  // top of stack held in registers, entries below it in memory
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_START: begin
        top_row_r   <= '0;
        top_col_r   <= '0;
        top_order_r <= '0;
        top_next_r  <= '0;
      end
      S_IDLE: begin
        if (in_fire) begin
          if (in_ch.mode == MODE_STEP) begin
            top_order_r <= shuffle_order(in_ch.random_bits);
            top_next_r  <= '0;
          end
          rr_r     <= in_ch.read_row;
          rc_r     <= in_ch.read_col;
          rd_row_r <= in_row_ext[RW-1:0];
          rd_col_r <= in_col_ext[CW-1:0];
          oob_r    <= in_oob;
        end
      end
      S_TRY: begin
        if (!top_next_r[2]) begin
          top_next_r <= top_next_r + 3'd1;
          tgt_row_r  <= try_tgt_row;
          tgt_col_r  <= try_col_tgt;
          mid_row_r  <= try_mid_row;
          mid_col_r  <= try_col_mid;
        end
      end
      S_POP: begin
        {top_row_r, top_col_r, top_order_r, top_next_r} <= stk_rd_r;
      end
      S_CARVE_END: begin
        if (fire) begin
          top_row_r   <= tgt_row_r;
          top_col_r   <= tgt_col_r;
          top_order_r <= '0;
          top_next_r  <= '0;
        end
      end
      default: begin
        top_next_r <= top_next_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (stk_wr_en) begin
      stk_mem[depth_m1[SAW-1:0]] <= {top_row_r, top_col_r, top_order_r, top_next_r};
    end
    if (stk_rd_en) begin
      stk_rd_r <= stk_mem[depth_m2[SAW-1:0]];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_row_r  <= emit_is_read ? rr_r : emit_row_ext[3:0];
      out_col_r  <= emit_is_read ? rc_r : emit_col_ext[3:0];
      out_kind_r <= emit_kind;
      out_fin_r  <= emit_fin;
      out_last_r <= emit_last;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.cell_row  = out_row_r;
  assign out_ch.cell_col  = out_col_r;
  assign out_ch.cell_kind = out_kind_r;
  assign out_ch.finished  = out_fin_r;
  assign out_ch.last      = out_last_r;

endmodule

// ----- tb/maze_dfs_carver_core_tb.sv -----
// self-checking testbench for the depth-first maze carver core
`timescale 1ns / 100ps

module maze_dfs_carver_core_tb;
  import mdc_pkg::*;

  localparam int         ROWS          = ROWS_DEF;
  localparam int         COLS          = COLS_DEF;
  localparam int         DEPTH         = STACK_DEPTH_DEF;
  localparam int         NCELLS        = ROWS * COLS;
  localparam logic [1:0] MODE_NOISE    = 2'd3;
  localparam int         RANDOM_ITEMS  = 310;
  localparam int         HOLD_CYCLES   = 400;
  localparam int         SETTLE_CYCLES = 100;
  localparam int         MAX_REPORTS   = 10;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] bits;
    logic [3:0] row;
    logic [3:0] col;
  } cmd_t;

  typedef struct packed {
    logic [3:0] row;
    logic [3:0] col;
    kind_t      kind;
    logic       finished;
    logic       last;
  } cell_res_t;

  typedef struct packed {
    logic [7:0] pos;
    logic [7:0] order;
    logic [2:0] next;
  } frame_t;

  typedef struct packed {
    cmd_t  cmd;
    logic  typed;
    kind_t kind;
    logic  finished;
  } script_row_t;

  logic clk = 1'b0;
  logic rst_n;

  mdc_in_if  in_if ();
  mdc_out_if out_if ();

  maze_dfs_carver_core dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_if),
    .out_ch(out_if)
  );

  always #5 clk = ~clk;

  // shadow copy of the carver
  logic        wall_map [NCELLS];
  frame_t      path_stack [DEPTH];
  int          path_len;
  int          goal_cell;
  phase_t      walk_ph;

  cell_res_t   pending_cells [$];
  script_row_t script [$];
  int          mismatches = 0;
  int          tx_idle_pct = 24;
  int          rx_idle_pct = 58;
  logic        rx_hold = 1'b0;

  function automatic logic [7:0] shuffle_draws(logic [7:0] draws);
    logic [1:0] slot [4];
    logic [1:0] pick;
    logic [1:0] held;
    for (int i = 0; i < 4; i++) slot[i] = 2'(i);
    for (int i = 0; i < 4; i++) begin
      pick       = draws[2*i +: 2];
      held       = slot[pick];
      slot[pick] = slot[i];
      slot[i]    = held;
    end
    return {slot[3], slot[2], slot[1], slot[0]};
  endfunction

  function automatic void post_cell(int row, int col, kind_t kind, logic fin, logic lst);
    cell_res_t r;
    r.row      = 4'(row);
    r.col      = 4'(col);
    r.kind     = kind;
    r.finished = fin;
    r.last     = lst;
    pending_cells.push_back(r);
  endfunction

  function automatic void advance_maze(cmd_t c);
    frame_t top;
    int     row, col, dr, dc, r2, c2, far, mid;
    logic   pushed;
    logic   fin;
    kind_t  kind;
    if (c.mode == MODE_START) begin
      for (int i = 0; i < NCELLS; i++) wall_map[i] = 1'b1;
      wall_map[0]   = 1'b0;
      path_stack[0] = '0;
      path_len      = 1;
      goal_cell     = 0;
      walk_ph       = PH_WAIT;
      post_cell(0, 0, KIND_PASSAGE, 1'b0, 1'b1);
    end else if (c.mode == MODE_READ) begin
      fin = (walk_ph == PH_DONE);
      if (int'(c.row) >= ROWS || int'(c.col) >= COLS) begin
        post_cell(int'(c.row), int'(c.col), KIND_WALL, fin, 1'b1);
      end else begin
        far  = int'(c.row) * COLS + int'(c.col);
        kind = wall_map[far] ? KIND_WALL : KIND_PASSAGE;
        if (fin && far == goal_cell) kind = KIND_GOAL;
        else if (fin && far == 0) kind = KIND_START;
        post_cell(int'(c.row), int'(c.col), kind, fin, 1'b1);
      end
    end else if (c.mode == MODE_STEP && walk_ph == PH_WAIT && path_len > 0) begin
      path_stack[path_len-1].order = shuffle_draws(c.bits);
      path_stack[path_len-1].next  = 3'd0;
      pushed = 1'b0;
      while (path_len > 0 && !pushed) begin
        top = path_stack[path_len-1];
        row = int'(top.pos) / COLS;
        col = int'(top.pos) % COLS;
        while (top.next < 3'd4 && !pushed) begin
          dr = 0;
          dc = 0;
          // north and south move along the columns, east and west along the rows
          case (dir_t'(top.order[2*top.next +: 2]))
            DIR_NORTH: dc = -1;
            DIR_EAST:  dr = 1;
            DIR_SOUTH: dc = 1;
            default:   dr = -1;
          endcase
          top.next = top.next + 3'd1;
          r2 = row + 2 * dr;
          c2 = col + 2 * dc;
          // a full stack blocks the direction like a carved cell
          if (r2 >= 0 && r2 < ROWS && c2 >= 0 && c2 < COLS && path_len < DEPTH) begin
            far = r2 * COLS + c2;
            if (wall_map[far]) begin
              mid                    = (row + dr) * COLS + col + dc;
              wall_map[mid]          = 1'b0;
              wall_map[far]          = 1'b0;
              path_stack[path_len-1] = top;
              path_stack[path_len]   = {8'(far), 8'd0, 3'd0};
              path_len++;
              goal_cell = far;
              post_cell(row + dr, col + dc, KIND_PASSAGE, 1'b0, 1'b0);
              post_cell(r2, c2, KIND_PASSAGE, 1'b0, 1'b1);
              pushed = 1'b1;
            end
          end
        end
        if (!pushed) path_len--;
      end
      if (!pushed) begin
        walk_ph = PH_DONE;
        if (goal_cell != 0) post_cell(0, 0, KIND_START, 1'b1, 1'b0);
        post_cell(goal_cell / COLS, goal_cell % COLS, KIND_GOAL, 1'b1, 1'b1);
      end
    end
  endfunction

  function automatic void add_row(logic [1:0] mode, logic [7:0] bits, logic [3:0] row,
                                  logic [3:0] col, logic typed, kind_t kind, logic fin);
    script_row_t s;
    s.cmd.mode = mode;
    s.cmd.bits = bits;
    s.cmd.row  = row;
    s.cmd.col  = col;
    s.typed    = typed;
    s.kind     = kind;
    s.finished = fin;
    script.push_back(s);
  endfunction

  // mostly well-formed walks, with reads, restarts and ignored items mixed in
  function automatic cmd_t random_cmd();
    cmd_t c;
    int   roll;
    c.bits = 8'($urandom_range(255));
    c.row  = 4'($urandom_range(15));
    c.col  = 4'($urandom_range(15));
    roll   = $urandom_range(99);
    if (walk_ph == PH_WAIT) begin
      if (roll < 84) c.mode = MODE_STEP;
      else if (roll < 95) c.mode = MODE_READ;
      else if (roll < 99) c.mode = MODE_NOISE;
      else c.mode = MODE_START;
    end else begin
      if (roll < 30) c.mode = MODE_START;
      else if (roll < 80) c.mode = MODE_READ;
      else if (roll < 90) c.mode = MODE_STEP;
      else c.mode = MODE_NOISE;
    end
    // aim some reads of a finished maze at the goal and the player start
    if (c.mode == MODE_READ && walk_ph == PH_DONE) begin
      roll = $urandom_range(99);
      if (roll < 30) begin
        c.row = 4'(goal_cell / COLS);
        c.col = 4'(goal_cell % COLS);
      end else if (roll < 45) begin
        c.row = 4'd0;
        c.col = 4'd0;
      end
    end
    return c;
  endfunction

  task automatic run_item(input cmd_t c, input logic typed, input kind_t kind,
                          input logic fin, output logic counted);
    int        base;
    cell_res_t r;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.mode        <= c.mode;
    in_if.random_bits <= c.bits;
    in_if.read_row    <= c.row;
    in_if.read_col    <= c.col;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    base = pending_cells.size();
    advance_maze(c);
    counted = (pending_cells.size() > base);
    if (typed) begin
      while (pending_cells.size() > base) void'(pending_cells.pop_back());
      r.row      = (c.mode == MODE_START) ? 4'd0 : c.row;
      r.col      = (c.mode == MODE_START) ? 4'd0 : c.col;
      r.kind     = kind;
      r.finished = fin;
      r.last     = 1'b1;
      pending_cells.push_back(r);
    end
  endtask

  task automatic hold_receiver(input int cycles);
    rx_hold <= 1'b1;
    repeat (cycles) @(posedge clk);
    rx_hold <= 1'b0;
  endtask

  task automatic check_cell();
    cell_res_t got;
    cell_res_t want;
    got.row      = out_if.cell_row;
    got.col      = out_if.cell_col;
    got.kind     = kind_t'(out_if.cell_kind);
    got.finished = out_if.finished;
    got.last     = out_if.last;
    if (pending_cells.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("[%0t] cell with none pending: row %0d col %0d kind %0d fin %0b last %0b",
                 $time, got.row, got.col, got.kind, got.finished, got.last);
    end else begin
      want = pending_cells.pop_front();
      if (got.row !== want.row || got.col !== want.col || got.kind !== want.kind ||
          got.finished !== want.finished || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("[%0t] cell mismatch: expected row %0d col %0d kind %0d fin %0b last %0b",
                   $time, want.row, want.col, want.kind, want.finished, want.last);
          $display("[%0t]                got      row %0d col %0d kind %0d fin %0b last %0b",
                   $time, got.row, got.col, got.kind, got.finished, got.last);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) check_cell();
    out_if.ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
  end

  initial begin
    int   n;
    logic counted;
    logic rx_held;
    logic drained;
    rst_n             <= 1'b0;
    in_if.valid       <= 1'b0;
    in_if.mode        <= MODE_START;
    in_if.random_bits <= 8'd0;
    in_if.read_row    <= 4'd0;
    in_if.read_col    <= 4'd0;
    for (int i = 0; i < NCELLS; i++) wall_map[i] = 1'b1;
    path_len  = 0;
    goal_cell = 0;
    walk_ph   = PH_IDLE;
    rx_held   = 1'b0;
    drained   = 1'b0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // reads after reset, ignored items, first carving steps and a restart
    add_row(MODE_READ,  8'h00,  4'd0,  4'd0,  1'b1, KIND_WALL,    1'b0);
    add_row(MODE_READ,  8'hFF,  4'd15, 4'd15, 1'b1, KIND_WALL,    1'b0);
    add_row(MODE_STEP,  8'hA5,  4'd3,  4'd4,  1'b0, KIND_WALL,    1'b0);
    add_row(MODE_NOISE, 8'h5A,  4'd7,  4'd9,  1'b0, KIND_WALL,    1'b0);
    add_row(MODE_START, 8'h00,  4'd0,  4'd0,  1'b1, KIND_PASSAGE, 1'b0);
    add_row(MODE_READ,  8'h00,  4'd0,  4'd0,  1'b1, KIND_PASSAGE, 1'b0);
    add_row(MODE_STEP,  8'h00,  4'd0,  4'd0,  1'b0, KIND_WALL,    1'b0);
    add_row(MODE_STEP,  8'hFF,  4'd15, 4'd15, 1'b0, KIND_WALL,    1'b0);
    add_row(MODE_STEP,  8'h55,  4'd5,  4'd10, 1'b0, KIND_WALL,    1'b0);
    add_row(MODE_STEP,  8'hAA,  4'd10, 4'd5,  1'b0, KIND_WALL,    1'b0);
    // both coordinates odd is never carved
    add_row(MODE_READ,  8'h00,  4'd15, 4'd15, 1'b1, KIND_WALL,    1'b0);
    add_row(MODE_READ,  8'h00,  4'd1,  4'd0,  1'b0, KIND_WALL,    1'b0);
    add_row(MODE_NOISE, 8'hFF,  4'd15, 4'd0,  1'b0, KIND_WALL,    1'b0);
    add_row(MODE_STEP,  8'h1B,  4'd0,  4'd0,  1'b0, KIND_WALL,    1'b0);
    add_row(MODE_STEP,  8'hE4,  4'd0,  4'd0,  1'b0, KIND_WALL,    1'b0);
    add_row(MODE_READ,  8'h00,  4'd15, 4'd0,  1'b0, KIND_WALL,    1'b0);
    add_row(MODE_START, 8'hFF,  4'd15, 4'd15, 1'b1, KIND_PASSAGE, 1'b0);
    add_row(MODE_READ,  8'h00,  4'd2,  4'd0,  1'b0, KIND_WALL,    1'b0);
    add_row(MODE_STEP,  8'h00,  4'd0,  4'd0,  1'b0, KIND_WALL,    1'b0);
    add_row(MODE_READ,  8'h00,  4'd0,  4'd15, 1'b0, KIND_WALL,    1'b0);
    add_row(MODE_STEP,  8'h39,  4'd9,  4'd6,  1'b0, KIND_WALL,    1'b0);

    foreach (script[i])
      run_item(script[i].cmd, script[i].typed, script[i].kind, script[i].finished, counted);

    n = 0;
    while (n < RANDOM_ITEMS) begin
      if (n < RANDOM_ITEMS / 3) begin
        tx_idle_pct = 24;
        rx_idle_pct <= 58;
      end else if (n < 2 * RANDOM_ITEMS / 3) begin
        tx_idle_pct = 58;
        rx_idle_pct <= 24;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
      end
      // long receiver stall while items keep coming, so the input backs up
      if (!rx_held && n >= 40) begin
        rx_held = 1'b1;
        fork
          hold_receiver(HOLD_CYCLES);
        join_none
      end
      // sender waits until every pending cell has come out
      if (!drained && n >= 150) begin
        drained = 1'b1;
        in_if.valid <= 1'b0;
        @(posedge clk);
        while (pending_cells.size() != 0) @(posedge clk);
      end
      run_item(random_cmd(), 1'b0, KIND_WALL, 1'b0, counted);
      if (counted) n++;
    end

    in_if.valid <= 1'b0;
    while (pending_cells.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_cells.size() == 0) begin
      $display("maze_dfs_carver_core_tb: PASS");
    end else begin
      $display("maze_dfs_carver_core_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("maze_dfs_carver_core_tb: FAIL");
    $finish;
  end

endmodule

// ----- filelist.f -----
design/mdc_pkg.sv
design/mdc_if.sv
design/mdc_grid.sv
design/maze_dfs_carver_core.sv
tb/maze_dfs_carver_core_tb.sv
